// ----- hdl/mpq_pkg.sv -----
// Shared types, codes and the control store for the linear-scan max-priority queue.
// Used by the channel interfaces, the sequencer and the top level. No dependencies.
package mpq_pkg;

  localparam int VALUE_W      = 32;
  localparam int STATUS_W     = 2;
  localparam int OCC_W        = 7;
  localparam int DEF_CAPACITY = 64;
  localparam int STEP_W       = 4;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef logic [STEP_W-1:0] step_t;

  // Hold the step while the named side is not ready.
  typedef enum logic [1:0] {
    W_NONE   = 2'd0,
    W_INPUT  = 2'd1,
    W_OUTPUT = 2'd2
  } wait_t;

  // Jump conditions; when false the step counter advances.
  typedef enum logic [2:0] {
    C_NEVER  = 3'd0,
    C_ALWAYS = 3'd1,
    C_POP    = 3'd2,
    C_EMPTY  = 3'd3,
    C_FULL   = 3'd4,
    C_LAST   = 3'd5,
    C_MORE   = 3'd6
  } cond_t;

  typedef enum logic [1:0] {
    A_IDX   = 2'd0,
    A_LAST  = 2'd1,
    A_BEST  = 2'd2,
    A_COUNT = 2'd3
  } addr_sel_t;

  typedef enum logic [1:0] {
    RES_OK_MAX  = 2'd0,
    RES_OK_ZERO = 2'd1,
    RES_EMPTY   = 2'd2,
    RES_FULL    = 2'd3
  } res_sel_t;

  typedef struct packed {
    wait_t     wt;
    cond_t     cond;
    step_t     target;
    addr_sel_t addr_sel;
    logic      rd_en;
    logic      wr_en;
    logic      wr_ram;     // write data from the RAM read port, else the input word
    logic      idx_clr;
    logic      idx_inc;
    logic      best_init;
    logic      best_cmp;
    logic      cnt_inc;
    logic      cnt_dec;
    logic      emit;
    res_sel_t  res_sel;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic out_busy;
    logic pop;
    logic empty;
    logic full;
    logic last;
  } flags_t;

  localparam step_t S_IDLE     = 4'd0;
  localparam step_t S_DISPATCH = 4'd1;
  localparam step_t S_PUSH     = 4'd2;
  localparam step_t S_WRITE    = 4'd3;
  localparam step_t S_EMIT_PSH = 4'd4;
  localparam step_t S_POP      = 4'd5;
  localparam step_t S_RD0      = 4'd6;
  localparam step_t S_FIRST    = 4'd7;
  localparam step_t S_SCAN     = 4'd8;
  localparam step_t S_RD_LAST  = 4'd9;
  localparam step_t S_MOVE     = 4'd10;
  localparam step_t S_EMIT_POP = 4'd11;
  localparam step_t S_EMIT_EMP = 4'd12;
  localparam step_t S_EMIT_FUL = 4'd13;

  localparam ctrl_t CTRL_NOP = '{
    wt: W_NONE, cond: C_NEVER, target: S_IDLE, addr_sel: A_IDX,
    rd_en: 1'b0, wr_en: 1'b0, wr_ram: 1'b0, idx_clr: 1'b0, idx_inc: 1'b0,
    best_init: 1'b0, best_cmp: 1'b0, cnt_inc: 1'b0, cnt_dec: 1'b0,
    emit: 1'b0, res_sel: RES_OK_ZERO
  };

  function automatic ctrl_t ucode(step_t pc);
    ctrl_t w;
    w = CTRL_NOP;
    unique case (pc)
      S_IDLE: begin
        w.wt = W_INPUT;
      end
      S_DISPATCH: begin
        w.cond   = C_POP;
        w.target = S_POP;
      end
      S_PUSH: begin
        w.cond   = C_FULL;
        w.target = S_EMIT_FUL;
      end
      S_WRITE: begin
        w.addr_sel = A_COUNT;
        w.wr_en    = 1'b1;
        w.cnt_inc  = 1'b1;
      end
      S_EMIT_PSH: begin
        w.wt      = W_OUTPUT;
        w.emit    = 1'b1;
        w.res_sel = RES_OK_ZERO;
        w.cond    = C_ALWAYS;
        w.target  = S_IDLE;
      end
      S_POP: begin
        w.cond    = C_EMPTY;
        w.target  = S_EMIT_EMP;
        w.idx_clr = 1'b1;
      end
      S_RD0: begin
        w.rd_en   = 1'b1;
        w.idx_inc = 1'b1;
      end
      S_FIRST: begin
        w.rd_en     = 1'b1;
        w.idx_inc   = 1'b1;
        w.best_init = 1'b1;
        w.cond      = C_LAST;
        w.target    = S_RD_LAST;
      end
      S_SCAN: begin
        w.rd_en    = 1'b1;
        w.idx_inc  = 1'b1;
        w.best_cmp = 1'b1;
        w.cond     = C_MORE;
        w.target   = S_SCAN;
      end
      S_RD_LAST: begin
        w.rd_en    = 1'b1;
        w.addr_sel = A_LAST;
      end
      S_MOVE: begin
        w.wr_en    = 1'b1;
        w.wr_ram   = 1'b1;
        w.addr_sel = A_BEST;
        w.cnt_dec  = 1'b1;
      end
      S_EMIT_POP: begin
        w.wt      = W_OUTPUT;
        w.emit    = 1'b1;
        w.res_sel = RES_OK_MAX;
        w.cond    = C_ALWAYS;
        w.target  = S_IDLE;
      end
      S_EMIT_EMP: begin
        w.wt      = W_OUTPUT;
        w.emit    = 1'b1;
        w.res_sel = RES_EMPTY;
        w.cond    = C_ALWAYS;
        w.target  = S_IDLE;
      end
      S_EMIT_FUL: begin
        w.wt      = W_OUTPUT;
        w.emit    = 1'b1;
        w.res_sel = RES_FULL;
        w.cond    = C_ALWAYS;
        w.target  = S_IDLE;
      end
      default: begin
        w.cond   = C_ALWAYS;
        w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ----- hdl/mpq_if.sv -----
// Valid/ready channel interfaces for the queue's request and response words.
// Depends on mpq_pkg for field widths.
interface mpq_in_if;
  import mpq_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      opcode;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, opcode, value, input ready);
  modport sink (input valid, opcode, value, output ready);
endinterface

interface mpq_out_if;
  import mpq_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] max_value;
  logic [STATUS_W-1:0]       status;
  logic [OCC_W-1:0]          occupancy;

  modport source (output valid, max_value, status, occupancy, input ready);
  modport sink (input valid, max_value, status, occupancy, output ready);
endinterface

// ----- hdl/mpq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ----- hdl/mpq_seq.sv -----
// Microprogram sequencer: step counter, control store lookup and jump logic.
// Depends on mpq_pkg for the control word, flags and the program itself.
module mpq_seq (
  input  logic            clk,
  input  logic            rst,
  input  mpq_pkg::flags_t flags,
  output mpq_pkg::ctrl_t  ctrl
);
  import mpq_pkg::*;

  step_t pc;
  step_t pc_next;
  logic  hold;
  logic  take;

  assign ctrl = ucode(pc);

  always_comb begin
    hold = (ctrl.wt == W_INPUT && !flags.in_valid) ||
           (ctrl.wt == W_OUTPUT && flags.out_busy);
    unique case (ctrl.cond)
      C_NEVER:  take = 1'b0;
      C_ALWAYS: take = 1'b1;
      C_POP:    take = flags.pop;
      C_EMPTY:  take = flags.empty;
      C_FULL:   take = flags.full;
      C_LAST:   take = flags.last;
      C_MORE:   take = !flags.last;
      default:  take = 1'b0;
    endcase
    if (hold) begin
      pc_next = pc;
    end else if (take) begin
      pc_next = ctrl.target;
    end else begin
      pc_next = pc + step_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_IDLE;
    end else begin
      pc <= pc_next;
    end
  end
endmodule

// ----- hdl/max_priority_queue_linear_scan_core.sv -----
// Max-priority queue over an unsorted entry RAM, scanned one entry per cycle on pop.
// Top level: datapath, entry RAM (mpq_ram) and microprogram sequencer (mpq_seq).
// Depends on mpq_pkg and the channel interfaces in mpq_if.
//
// Usage: req carries opcode (0 push value, 1 pop maximum) and value; rsp returns
// max_value, status (0 ok, 1 pop on empty, 2 push on full) and occupancy, one
// rsp word per req word, in order. Both channels move a word when valid and ready
// are high at a rising edge. One word is processed at a time.
// The time from one req acceptance to the next possible one depends on the operation:
// a push checks for full, writes and emits; a pop checks for empty, scans all held
// entries, moves the last entry into the maximum's slot and emits. The pop time is set
// by the scan through the RAM's single read port, one entry a cycle.
// The rsp word is registered; req is taken again while it still waits. If rsp is
// stalled when the next result is ready, the sequencer holds at its emit step.
// Reset (rst, synchronous) empties the queue and drops any pending rsp word; the
// RAM is not cleared, since only entries below the held count are ever read.
module max_priority_queue_linear_scan_core #(
  parameter int CAPACITY = mpq_pkg::DEF_CAPACITY
) (
  input  logic      clk,
  input  logic      rst,
  mpq_in_if.sink    req,
  mpq_out_if.source rsp
);
  import mpq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  ctrl_t  ctrl;
  flags_t flags;

  logic                      in_fire;
  logic                      out_busy;
  logic                      out_load;
  logic                      op_q;
  logic [VALUE_W-1:0]        val_q;
  logic [CW-1:0]             count;
  logic [CW-1:0]             idx;
  logic [AW-1:0]             rd_addr_q;
  logic [VALUE_W-1:0]        best_val;
  logic [AW-1:0]             best_idx;
  logic [AW-1:0]             ram_addr;
  logic [VALUE_W-1:0]        ram_wdata;
  logic [VALUE_W-1:0]        rd_data;
  logic [CW-1:0]             count_m1;
  logic                      best_upd;
  logic signed [VALUE_W-1:0] res_max;
  status_t                   res_status;
  logic                      out_valid;
  logic signed [VALUE_W-1:0] out_max;
  logic [STATUS_W-1:0]       out_status;
  logic [OCC_W-1:0]          out_occ;

  mpq_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctrl  (ctrl)
  );

  assign req.ready = (ctrl.wt == W_INPUT);
  assign in_fire   = req.valid && req.ready;
  assign out_busy  = out_valid && !rsp.ready;
  assign out_load  = ctrl.emit && !out_busy;
  assign count_m1  = count - CW'(1);

  always_comb begin
    flags.in_valid = req.valid;
    flags.out_busy = out_busy;
    flags.pop      = (op_q == OP_POP);
    flags.empty    = (count == '0);
    flags.full     = (count == CW'(CAPACITY));
    flags.last     = (CW'(rd_addr_q) + CW'(1)) >= count;
  end

  always_comb begin
    unique case (ctrl.addr_sel)
      A_IDX:   ram_addr = idx[AW-1:0];
      A_LAST:  ram_addr = count_m1[AW-1:0];
      A_BEST:  ram_addr = best_idx;
      A_COUNT: ram_addr = count[AW-1:0];
      default: ram_addr = idx[AW-1:0];
    endcase
    ram_wdata = ctrl.wr_ram ? rd_data : val_q;
  end

  mpq_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ctrl.wr_en),
    .waddr (ram_addr),
    .wdata (ram_wdata),
    .re    (ctrl.rd_en),
    .raddr (ram_addr),
    .rdata (rd_data)
  );

  // Strict compare keeps the first of equal maxima.
  assign best_upd = ctrl.best_init ||
                    (ctrl.best_cmp && ($signed(best_val) < $signed(rd_data)));

  always_comb begin
    unique case (ctrl.res_sel)
      RES_OK_MAX: begin
        res_max    = $signed(best_val);
        res_status = ST_OK;
      end
      RES_OK_ZERO: begin
        res_max    = '0;
        res_status = ST_OK;
      end
      RES_EMPTY: begin
        res_max    = '0;
        res_status = ST_EMPTY;
      end
      RES_FULL: begin
        res_max    = '0;
        res_status = ST_FULL;
      end
      default: begin
        res_max    = '0;
        res_status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctrl.cnt_inc) begin
        count <= count + CW'(1);
      end else if (ctrl.cnt_dec) begin
        count <= count_m1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_q  <= req.opcode;
      val_q <= req.value;
    end
    if (ctrl.idx_clr) begin
      idx <= '0;
    end else if (ctrl.idx_inc) begin
      idx <= idx + CW'(1);
    end
    if (ctrl.rd_en) begin
      rd_addr_q <= ram_addr;
    end
    if (best_upd) begin
      best_val <= rd_data;
      best_idx <= rd_addr_q;
    end
    if (out_load) begin
      out_max    <= res_max;
      out_status <= res_status;
      out_occ    <= OCC_W'(count);
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.max_value = out_max;
  assign rsp.status    = out_status;
  assign rsp.occupancy = out_occ;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("held count above capacity");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !req.ready)
    else $error("request taken while one is in progress");

  a_full_result: assert property (@(posedge clk) disable iff (rst)
    out_load && ctrl.res_sel == RES_FULL |-> count == CW'(CAPACITY))
    else $error("full status reported below capacity");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    out_load && ctrl.res_sel == RES_EMPTY |-> count == '0)
    else $error("empty status reported with entries held");

  a_pop_removes: assert property (@(posedge clk) disable iff (rst)
    ctrl.cnt_dec |-> count != '0 && !ctrl.cnt_inc)
    else $error("remove from an empty store");
endmodule
